[design/cdq_pkg.sv]
package cdq_pkg;

  // build defaults
  localparam int MAX_DEPTH_DEF  = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // capacity register
  localparam int                CAP_W     = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam logic [1:0]       REG_CAP_ADDR = 2'd0;

  localparam int ACT_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE      = 3'd0,
    ACT_INS_FRONT = 3'd1,
    ACT_INS_REAR  = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_REAR  = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_PUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic capture;
    logic load_out;
  } cdq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read;
  } cdq_sts_t;

endpackage

[design/cdq_ram.sv]
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/cdq_ctrl.sv]
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cdq_pkg::cdq_cmd_t cmd,
  input  cdq_pkg::cdq_sts_t sts
);

  import cdq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = sts.need_read ? ST_READ : ST_PUSH;
      ST_READ: state_nxt = ST_PUSH;
      ST_PUSH: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_READ: cmd.capture = 1'b1;
      ST_PUSH: begin
        cmd.load_out = slot_free;
        if (slot_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[design/cdq_dp.sv]
module cdq_dp #(
  parameter int MAX_DEPTH  = cdq_pkg::MAX_DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cdq_pkg::cdq_cmd_t          cmd,
  output cdq_pkg::cdq_sts_t          sts,
  input  logic [cdq_pkg::ACT_W-1:0]  in_action,
  input  logic [DATA_WIDTH-1:0]      in_value,
  input  logic                       cap_we,
  input  logic [cdq_pkg::CAP_W-1:0]  cap_wdata,
  output logic [cdq_pkg::CAP_W-1:0]  cap_value,
  output logic                       res_ok,
  output logic                       res_empty,
  output logic                       res_full,
  output logic [DATA_WIDTH-1:0]      res_front,
  output logic [DATA_WIDTH-1:0]      res_rear
);

  import cdq_pkg::*;

  localparam int AW   = $clog2(MAX_DEPTH);
  localparam int CW   = $clog2(MAX_DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]      cap_r;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         occ_r, occ_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt, rear_r, rear_nxt;
  logic [ACT_W-1:0]      act_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic                  ok_r, ok_nxt;
  logic                  rd_front_r, rd_front_nxt;

  logic                  out_ok_r, out_empty_r, out_full_r;
  logic [DATA_WIDTH-1:0] out_front_r, out_rear_r;

  logic [CMPW-1:0]       eff_cap;
  logic                  is_full, is_empty;
  logic [AW-1:0]         head_inc, head_dec, tail_pos, last2_pos;
  logic [SW-1:0]         tail_sum, last2_sum;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] rdata;

  // capacity saturates at the ring size
  assign eff_cap  = (CMPW'(cap_r) > CMPW'(MAX_DEPTH)) ? CMPW'(MAX_DEPTH) : CMPW'(cap_r);
  assign is_full  = CMPW'(occ_r) >= eff_cap;
  assign is_empty = (occ_r == '0);

  assign head_inc = (head_r == AW'(MAX_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? AW'(MAX_DEPTH - 1) : head_r - AW'(1);

  // sums stay below twice the ring size, one subtract wraps them
  assign tail_sum  = SW'(head_r) + SW'(occ_r);
  assign last2_sum = tail_sum - SW'(2);
  assign tail_pos  = (tail_sum >= SW'(MAX_DEPTH)) ? AW'(tail_sum - SW'(MAX_DEPTH))
                                                   : AW'(tail_sum);
  assign last2_pos = (last2_sum >= SW'(MAX_DEPTH)) ? AW'(last2_sum - SW'(MAX_DEPTH))
                                                    : AW'(last2_sum);

  always_comb begin
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    front_nxt    = front_r;
    rear_nxt     = rear_r;
    ok_nxt       = 1'b1;
    rd_front_nxt = 1'b1;
    we           = 1'b0;
    waddr        = head_r;
    re           = 1'b0;
    raddr        = head_r;
    unique case (act_r)
      ACT_INS_FRONT: begin
        if (is_full) begin
          ok_nxt = 1'b0;
        end else begin
          head_nxt  = head_dec;
          occ_nxt   = occ_r + CW'(1);
          we        = 1'b1;
          waddr     = head_dec;
          front_nxt = data_r;
          if (is_empty) rear_nxt = data_r;
        end
      end
      ACT_INS_REAR: begin
        if (is_full) begin
          ok_nxt = 1'b0;
        end else begin
          occ_nxt  = occ_r + CW'(1);
          we       = 1'b1;
          waddr    = tail_pos;
          rear_nxt = data_r;
          if (is_empty) front_nxt = data_r;
        end
      end
      ACT_DEL_FRONT: begin
        if (is_empty) begin
          ok_nxt = 1'b0;
        end else begin
          head_nxt = head_inc;
          occ_nxt  = occ_r - CW'(1);
          if (occ_r == CW'(2)) begin
            front_nxt = rear_r;
          end else if (occ_r > CW'(2)) begin
            re    = 1'b1;
            raddr = head_inc;
          end
        end
      end
      ACT_DEL_REAR: begin
        if (is_empty) begin
          ok_nxt = 1'b0;
        end else begin
          occ_nxt      = occ_r - CW'(1);
          rd_front_nxt = 1'b0;
          if (occ_r == CW'(2)) begin
            rear_nxt = front_r;
          end else if (occ_r > CW'(2)) begin
            re    = 1'b1;
            raddr = last2_pos;
          end
        end
      end
      default: ;
    endcase
  end

  assign sts.need_read = re;

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && we),
    .waddr (waddr),
    .wdata (data_r),
    .re    (cmd.exec && re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      head_r <= '0;
      occ_r  <= '0;
    end else begin
      if (cap_we) cap_r <= cap_wdata;
      if (cmd.exec) begin
        head_r <= head_nxt;
        occ_r  <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r  <= in_action;
      data_r <= in_value;
    end
    if (cmd.exec) begin
      front_r    <= front_nxt;
      rear_r     <= rear_nxt;
      ok_r       <= ok_nxt;
      rd_front_r <= rd_front_nxt;
    end else if (cmd.capture) begin
      if (rd_front_r) front_r <= rdata;
      else            rear_r  <= rdata;
    end
    if (cmd.load_out) begin
      out_ok_r    <= ok_r;
      out_empty_r <= is_empty;
      out_full_r  <= is_full;
      out_front_r <= is_empty ? '0 : front_r;
      out_rear_r  <= is_empty ? '0 : rear_r;
    end
  end

  assign cap_value = cap_r;
  assign res_ok    = out_ok_r;
  assign res_empty = out_empty_r;
  assign res_full  = out_full_r;
  assign res_front = out_front_r;
  assign res_rear  = out_rear_r;

endmodule

[design/circular_deque.sv]
// circular_deque: double-ended queue held in a ring of MAX_DEPTH words of RAM,
// with a usable size set by the capacity register (values above MAX_DEPTH act as
// MAX_DEPTH, zero makes every insert fail). Each input item carries an action in
// in_tuser (0 none, 1 insert front, 2 insert rear, 3 delete front, 4 delete rear,
// 5 to 7 act as none) and a data word in in_tdata; each one yields exactly one result
// item with the success flag and the state after the action: empty, full, and the
// front and rear entries (zero while empty). Inserts on a full deque and deletes on an
// empty one fail and leave the state unchanged. Front and rear are kept in registers,
// so an item passes through accept, execute and load of the result register, and a
// delete that leaves two or more entries adds a read step, as it must fetch the new end
// entry through the RAM's registered read port. One item is worked at a time; the
// next is taken in the cycle after the result register is loaded, while that result
// may still wait for out_tready; a new result waits for the result register to free
// up. Capacity is written over the APB port at address 0; the user must write it only
// while no item is in flight, which the block does not enforce; reset value 1024.
module circular_deque #(
  parameter int MAX_DEPTH  = cdq_pkg::MAX_DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input items
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] in_tdata,    // value
  input  logic [cdq_pkg::ACT_W-1:0]             in_tuser,    // action
  // result items
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     out_tdata,   // front_value, rear_value
  output logic [2:0]                            out_tuser,   // ok, is_empty, is_full
  // configuration
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [1:0]                            cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  import cdq_pkg::*;

  localparam int OUT_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

  cdq_cmd_t              cmd;
  cdq_sts_t              sts;
  logic                  cap_we;
  logic [CAP_W-1:0]      cap_value;
  logic                  res_ok, res_empty, res_full;
  logic [DATA_WIDTH-1:0] res_front, res_rear;

  // capacity is the only register, at address 0
  assign cfg_pready = 1'b1;
  assign cap_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == REG_CAP_ADDR);
  assign cfg_prdata = 32'(cap_value);

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cdq_dp #(
    .MAX_DEPTH  (MAX_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_tuser),
    .in_value  (in_tdata[DATA_WIDTH-1:0]),
    .cap_we    (cap_we),
    .cap_wdata (cfg_pwdata[CAP_W-1:0]),
    .cap_value (cap_value),
    .res_ok    (res_ok),
    .res_empty (res_empty),
    .res_full  (res_full),
    .res_front (res_front),
    .res_rear  (res_rear)
  );

  // front in the low half, rear above it, zero padding on top
  assign out_tdata = OUT_W'({res_rear, res_front});
  assign out_tuser = {res_full, res_empty, res_ok};

endmodule

[design/cdq_checker.sv]
module cdq_checker #(
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((2*DATA_WIDTH+7)/8)*8-1:0]   out_tdata,
  input logic [2:0]                          out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an empty deque reports zero front and rear
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0)
    else $error("nonzero data with empty flag");

  // a result is never shown in the cycle right after its item is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // no result right out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind circular_deque cdq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
